/* hw/rtl/llwd_pkg.sv */
// shared types and constants for the least-loaded worker dispatcher
// no dependencies; imported by llwd_cell and least_loaded_worker_dispatch
`default_nettype none

package llwd_pkg;

  localparam int MaxWorkers = 16;
  localparam int IdxW       = $clog2(MaxWorkers);
  localparam int NumW       = $clog2(MaxWorkers + 1);
  localparam int CfgW       = 5;
  localparam int CntW       = 26;
  localparam int LenW       = 25;
  localparam int TagW       = 32;
  localparam int WorkerW    = 4;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  typedef struct packed {
    logic        [LenW-1:0] block_length;
    logic signed [TagW-1:0] block_tag;
  } in_item_t;

  typedef struct packed {
    logic        [WorkerW-1:0] worker;
    logic signed [TagW-1:0]    tag_out;
  } out_item_t;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic [CntW-1:0] val;
    logic [IdxW-1:0] idx;
  } tok_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [CntW-1:0] prev_min;
    logic [NumW-1:0] num;
    logic            add_en;
    logic [IdxW-1:0] add_idx;
    logic [LenW-1:0] add_len;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/llwd_cell.sv */
// one worker cell: holds, normalizes and charges a usage counter; updates the running minimum
// depends on llwd_pkg
`default_nettype none

module llwd_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire [llwd_pkg::IdxW-1:0]   idx_i,
  input  llwd_pkg::cell_ctl_t        ctl_i,
  input  wire                        go_i,
  input  llwd_pkg::tok_t             tok_i,
  output logic                       go_o,
  output llwd_pkg::tok_t             tok_o
);
  import llwd_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            go_q;
  tok_t            tok_q, tok_d;
  logic            active;
  logic [CntW-1:0] reduced;
  logic            better;
  logic [CntW:0]   sum;

  assign active  = NumW'(idx_i) < ctl_i.num;
  assign reduced = (cnt_q > ctl_i.prev_min) ? (cnt_q - ctl_i.prev_min) : '0;
  assign better  = (idx_i == '0) || (reduced < tok_i.val);
  assign sum     = {1'b0, cnt_q} + (CntW + 1)'(ctl_i.add_len);

  always_comb begin
    cnt_d = cnt_q;
    if (go_i && active) begin
      cnt_d = reduced;
    end else if (ctl_i.add_en && (ctl_i.add_idx == idx_i)) begin
      cnt_d = sum[CntW] ? CntMax : sum[CntW-1:0];
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (active && better) begin
      tok_d.val = reduced;
      tok_d.idx = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      go_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      go_q  <= go_i;
    end
  end

  // token is payload, only meaningful alongside go
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      tok_q <= tok_d;
    end
  end

  assign go_o  = go_q;
  assign tok_o = tok_q;

endmodule

`default_nettype wire

/* hw/rtl/least_loaded_worker_dispatch.sv */
// top level of the least-loaded worker dispatcher: controller plus a chain of worker cells
// depends on llwd_pkg and llwd_cell
//
// usage:
//   input channel (in_valid_i / in_stall_o / in_item_i) takes one block transaction:
//   its length in bytes and a tag. output channel (out_valid_o / out_stall_i /
//   out_item_o) returns one transaction per block: the chosen worker and the tag.
//   cfg_we_i / cfg_wdata_i write the active worker count; write it only while idle.
// timing:
//   with more than one active worker a go pulse walks the chain of MaxWorkers cells,
//   one cell per cycle, carrying the running minimum; inactive cells pass it along.
//   the winner's counter gets the block length the cycle the pulse leaves the last
//   cell. the result then moves through the done state into the output register, and
//   the next block is accepted the cycle after the result is loaded, so a new block is
//   not taken before the last one has left the done state. one worker: worker 0, state
//   untouched, the block goes from idle to the done state and on into the output register.
// reset:
//   all usage counters and the remembered minimum clear to zero, worker count is 1.
// stall:
//   a result sits in the output register while out_stall_i is high. a following block
//   is accepted and fully processed meanwhile, then waits in the done state until the
//   output register frees up; in_stall_o stays high during that wait.
`default_nettype none

module least_loaded_worker_dispatch (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire [llwd_pkg::CfgW-1:0] cfg_wdata_i,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  llwd_pkg::in_item_t     in_item_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output llwd_pkg::out_item_t    out_item_o
);
  import llwd_pkg::*;

  // configuration
  logic [CfgW-1:0] worker_count_q;
  logic [NumW-1:0] num_active;

  // control
  state_e          state_q, state_d;
  logic            in_acc;
  logic            out_free;
  logic            add_en;
  logic            load_out;
  logic            start_q;

  // per-transaction payload
  logic [NumW-1:0] num_q;
  logic [LenW-1:0] len_q;
  logic [TagW-1:0] tag_q;
  logic [IdxW-1:0] res_worker_q;
  logic [CntW-1:0] prev_min_q;

  // output register
  logic            out_valid_q;
  out_item_t       out_q;

  // chain wiring
  logic [MaxWorkers:0] go;
  tok_t                tok [MaxWorkers+1];
  cell_ctl_t           ctl;

  // zero means one worker, anything above the cell count saturates
  always_comb begin
    if (worker_count_q == '0) begin
      num_active = NumW'(1);
    end else if (32'(worker_count_q) > MaxWorkers) begin
      num_active = NumW'(MaxWorkers);
    end else begin
      num_active = NumW'(worker_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worker_count_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      worker_count_q <= cfg_wdata_i;
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = (num_active > NumW'(1)) ? StScan : StDone;
        end
      end
      StScan: begin
        if (go[MaxWorkers]) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    add_en     = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      StIdle: in_stall_o = 1'b0;
      StScan: add_en     = go[MaxWorkers];
      StDone: load_out   = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      start_q     <= 1'b0;
      prev_min_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // kick the chain only when there is a real choice to make
      start_q <= in_acc && (num_active > NumW'(1));
      if (add_en) begin
        prev_min_q <= tok[MaxWorkers].val;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      num_q        <= num_active;
      len_q        <= in_item_i.block_length;
      tag_q        <= in_item_i.block_tag;
      res_worker_q <= '0;
    end else if (add_en) begin
      res_worker_q <= tok[MaxWorkers].idx;
    end
    if (load_out) begin
      out_q.worker  <= WorkerW'(res_worker_q);
      out_q.tag_out <= tag_q;
    end
  end

  // broadcast to the cells; the add hits the winner as the token leaves the chain
  assign ctl.prev_min = prev_min_q;
  assign ctl.num      = num_q;
  assign ctl.add_en   = add_en;
  assign ctl.add_idx  = tok[MaxWorkers].idx;
  assign ctl.add_len  = len_q;

  assign go[0]  = start_q;
  assign tok[0] = '0;

  for (genvar g = 0; g < MaxWorkers; g++) begin : g_cell
    llwd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IdxW'(g)),
      .ctl_i  (ctl),
      .go_i   (go[g]),
      .tok_i  (tok[g]),
      .go_o   (go[g+1]),
      .tok_o  (tok[g+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // only one scan in flight along the chain
  a_single_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(go))
    else $error("more than one go pulse in the cell chain");

  // the pulse leaves the chain only while scanning
  a_go_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go[MaxWorkers] |-> (state_q == StScan))
    else $error("scan finished outside the scan state");

  // winner is always an active worker
  a_winner_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_en |-> (NumW'(tok[MaxWorkers].idx) < num_q))
    else $error("winner index beyond active worker count");

  // a result is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load_out)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

/* test/llwd_dispatch_checker.sv */
// scoreboard for the least-loaded worker dispatcher: mirrors the usage counters
// and predicts the worker for every accepted block transaction
// depends on llwd_pkg only
module llwd_dispatch_checker (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [llwd_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire                         in_valid_i,
  input  wire                         in_stall_i,
  input  llwd_pkg::in_item_t          in_item_i,
  input  wire                         out_valid_i,
  input  wire                         out_stall_i,
  input  llwd_pkg::out_item_t         out_item_i,
  output int                          pending_o,
  output int                          fail_count_o
);
  import llwd_pkg::*;

  logic [CntW-1:0] usage_cnt [MaxWorkers];
  logic [CntW-1:0] carry_min;
  logic [CfgW-1:0] worker_cfg;
  out_item_t       dispatch_q [$];
  int              fails;

  // one block; if several are active: normalize, pick the least loaded, charge it
  function automatic out_item_t pick_worker(input in_item_t blk);
    int unsigned     act;
    logic [IdxW-1:0] best;
    logic [CntW-1:0] best_val;
    logic [CntW:0]   sum;
    out_item_t       res;
    act = (worker_cfg == '0) ? 1 : (worker_cfg > MaxWorkers) ? MaxWorkers : worker_cfg;
    best = '0;
    best_val = '0;
    if (act > 1) begin
      for (int i = 0; i < act; i++) begin
        usage_cnt[i] = (usage_cnt[i] > carry_min) ? usage_cnt[i] - carry_min : '0;
        if (i == 0 || usage_cnt[i] < best_val) begin
          best = i[IdxW-1:0];
          best_val = usage_cnt[i];
        end
      end
      carry_min = best_val;
      sum = {1'b0, usage_cnt[best]} + blk.block_length;
      usage_cnt[best] = (sum > CntMax) ? CntMax : sum[CntW-1:0];
    end
    res.worker = WorkerW'(best);
    res.tag_out = blk.block_tag;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MaxWorkers; i++) usage_cnt[i] = '0;
      carry_min = '0;
      worker_cfg = CfgW'(1);
      dispatch_q.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (dispatch_q.size() == 0) begin
          $error("result with nothing outstanding: worker %0d tag %0d",
                 out_item_i.worker, out_item_i.tag_out);
          fails++;
        end else begin
          want = dispatch_q.pop_front();
          if (out_item_i.worker !== want.worker) begin
            $error("worker: expected %0d, got %0d", want.worker, out_item_i.worker);
            fails++;
          end
          if (out_item_i.tag_out !== want.tag_out) begin
            $error("tag_out: expected %0d, got %0d", want.tag_out, out_item_i.tag_out);
            fails++;
          end
        end
      end
      if (cfg_we_i) worker_cfg = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) dispatch_q.push_back(pick_worker(in_item_i));
      pending_o <= dispatch_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

/* test/least_loaded_worker_dispatch_tb.sv */
// testbench top for least_loaded_worker_dispatch: clock, reset, block traffic,
// worker count changes and the verdict; checking lives in llwd_dispatch_checker
// depends on llwd_pkg, least_loaded_worker_dispatch and llwd_dispatch_checker
module least_loaded_worker_dispatch_tb;
  import llwd_pkg::*;

  localparam int              CycleLimit   = 600000;
  localparam int              HoldCycles   = 400;
  localparam int              DrainCycles  = 40;
  localparam logic [LenW-1:0] LongestBlock = 25'h100_0000;
  localparam logic [LenW-1:0] AllOnesBlock = 25'h0FF_FFFF;
  localparam int              NumPhases    = 13;

  // random phases: worker count, transactions, sender idle %, receiver stall %
  localparam int PhaseCount [NumPhases] = '{16, 2, 31, 3, 0, 16, 1, 17, 8, -1, 16, 5, 2};
  localparam int PhaseItems [NumPhases] =
    '{150, 130, 130, 130, 60, 150, 60, 120, 130, 130, 150, 120, 120};
  localparam int PhaseIdle  [NumPhases] = '{0, 75, 0, 14, 14, 0, 75, 0, 75, 14, 0, 14, 0};
  localparam int PhaseStall [NumPhases] = '{0, 0, 75, 14, 14, 0, 75, 75, 0, 14, 75, 14, 0};

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we = 1'b0;
  logic [CfgW-1:0] cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_item_t        in_item = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_item;

  int pending;
  int fail_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int cycle_cnt = 0;

  least_loaded_worker_dispatch dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  llwd_dispatch_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: a hung block or a lost result ends here
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver: random stall per cycle, or one long hold-off when the sender asks
  initial begin
    int hold_served;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served < hold_requests) begin
        hold_served++;
        out_stall <= 1'b1;
        // stall stays high the whole stretch so the block backs up into its input
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // mostly small blocks, some over the whole range, a few at the edges
  function automatic logic [LenW-1:0] rand_length();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick < 12) return LenW'($urandom_range(255));
    if (pick < 16) return LenW'($urandom_range(65535));
    if (pick < 18) return LenW'($urandom_range(LongestBlock));
    if (pick == 18) return LongestBlock;
    return ($urandom_range(1) == 0) ? '0 : AllOnesBlock;
  endfunction

  function automatic logic signed [TagW-1:0] rand_tag();
    if ($urandom_range(9) == 0) return -1;
    return TagW'($urandom_range(32'h7FFF_FFFF, 0));
  endfunction

  // offer one block transaction, with random idle cycles ahead of it;
  // returns in the time step of the accepting edge
  task automatic send_block(input logic [LenW-1:0] len, input logic signed [TagW-1:0] tag);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= '{block_length: len, block_tag: tag};
    do @(posedge clk_i); while (in_stall);
  endtask

  // drain every outstanding result, then write the worker count while idle
  task automatic set_workers(input logic [CfgW-1:0] count);
    in_valid <= 1'b0;
    // pending is registered, so always step at least once
    do @(posedge clk_i); while (pending != 0);
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int count;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, no idling on either side
    // reset count of one: always worker 0, counters untouched
    send_block('0, 0);
    send_block(LongestBlock, -1);
    // zero count behaves as one worker
    set_workers(CfgW'(0));
    send_block(AllOnesBlock, 32'sh7FFF_FFFF);
    send_block(25'd100, 1);
    // full set of workers with extreme lengths
    set_workers(CfgW'(16));
    send_block(LongestBlock, 2);
    send_block(LongestBlock, 3);
    send_block('0, 4);
    send_block(AllOnesBlock, 5);
    send_block(25'd1, 6);
    send_block(LongestBlock, 7);
    // count above the worker limit saturates to all workers
    set_workers(CfgW'(31));
    send_block(LongestBlock, 8);
    send_block(25'd7, 9);
    send_block('0, 10);
    // shrink to two, piling large blocks on them
    set_workers(CfgW'(2));
    repeat (4) send_block(LongestBlock, 11);
    // grow again: held counters can sit below the remembered minimum
    set_workers(CfgW'(16));
    send_block(25'd5, 12);
    send_block('0, 13);
    send_block(LongestBlock, 14);

    // random phases
    for (int p = 0; p < NumPhases; p++) begin
      count = (PhaseCount[p] < 0) ? $urandom_range(31) : PhaseCount[p];
      set_workers(CfgW'(count));
      idle_pct = PhaseIdle[p];
      stall_pct = PhaseStall[p];
      // first phase: long receiver hold-off while the sender keeps pushing
      if (p == 0) hold_requests++;
      repeat (PhaseItems[p]) send_block(rand_length(), rand_tag());
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    // catch anything extra the block might still emit
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/llwd_pkg.sv
hw/rtl/llwd_cell.sv
hw/rtl/least_loaded_worker_dispatch.sv
test/llwd_dispatch_checker.sv
test/least_loaded_worker_dispatch_tb.sv
